// ----- hw/rtl/ranked_top_k_score_table_macros.svh -----
// Assertion macros for the ranked top-k score table.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef RANKED_TOP_K_SCORE_TABLE_MACROS_SVH
`define RANKED_TOP_K_SCORE_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RTK_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RTK_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rtk_pkg.sv -----
// Shared types, codes and helper functions of the ranked top-k score table.
// No dependencies; imported by the interfaces, the cell and the top level.
package rtk_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int PID_BITS_DEF = 16;
    localparam int ACTION_W     = 2;
    localparam int PID_W        = 16;
    localparam int SCORE_W      = 32;
    localparam int COUNT_W      = 7;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 7;

    typedef logic [ACTION_W-1:0] t_action;
    localparam t_action ACT_SUBMIT = 2'd0;
    localparam t_action ACT_UPDATE = 2'd1;
    localparam t_action ACT_CLEAR  = 2'd2;
    localparam t_action ACT_NONE   = 2'd3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ORDER = 1'd0;
    localparam t_cfg_idx CFG_MAX   = 1'd1;

    typedef logic signed [SCORE_W-1:0] t_score;

    // Per-cycle command broadcast to every cell
    typedef enum logic [2:0] {
        C_HOLD,
        C_LOAD_FIND,
        C_SHIFT,
        C_WRITE_NEW,
        C_REPLACE,
        C_SORT,
        C_LOAD_RANK
    } t_cell_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_DECIDE,
        S_SORT,
        S_LOAD,
        S_RANK,
        S_REPORT
    } t_state;

    typedef struct packed {
        t_cell_op op;
        logic     phase;
        logic     desc;
        t_score   score;
    } t_cell_ctrl;

    // a ranks strictly ahead of b under the given order
    function automatic logic is_better(logic desc, t_score a, t_score b);
        return desc ? (a > b) : (a < b);
    endfunction

endpackage

// ----- hw/rtl/rtk_in_if.sv -----
// Input item channel of the ranked top-k score table: valid/ready plus payload.
// Depends on rtk_pkg.
interface rtk_in_if import rtk_pkg::*; ();
    logic             valid;
    logic             ready;
    t_action          action;
    logic [PID_W-1:0] player_id;
    t_score           score;

    modport source (output valid, action, player_id, score, input ready);
    modport sink   (input valid, action, player_id, score, output ready);
endinterface

// ----- hw/rtl/rtk_out_if.sv -----
// Result channel of the ranked top-k score table: valid/ready plus payload.
// Depends on rtk_pkg.
interface rtk_out_if import rtk_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               accepted;
    logic               new_top;
    logic [COUNT_W-1:0] rank;
    logic [COUNT_W-1:0] entry_count;

    modport source (output valid, accepted, new_top, rank, entry_count, input ready);
    modport sink   (input valid, accepted, new_top, rank, entry_count, output ready);
endinterface

// ----- hw/rtl/rtk_cell.sv -----
// One slot of the sorted entry chain: holds an entry, a tag and two scan bits,
// and trades data with its neighbors. Depends on rtk_pkg.
module rtk_cell import rtk_pkg::*; #(
    parameter int CAPACITY       = CAPACITY_DEF,
    parameter int PLAYER_ID_BITS = PID_BITS_DEF,
    parameter int INDEX          = 0,
    localparam int CW            = $clog2(CAPACITY + 2)
) (
    input  logic                      i_clk,
    input  t_cell_ctrl                i_ctrl,
    input  logic [PLAYER_ID_BITS-1:0] i_pid,
    input  logic [CW-1:0]             i_sel,
    input  logic [CW-1:0]             i_n_work,
    input  t_score                    i_r_score,
    input  logic [PLAYER_ID_BITS-1:0] i_r_pid,
    input  logic                      i_r_tag,
    input  logic                      i_r_scan_a,
    input  logic                      i_r_scan_b,
    input  t_score                    i_l_score,
    input  logic [PLAYER_ID_BITS-1:0] i_l_pid,
    input  logic                      i_l_tag,
    input  logic                      i_swap_l,
    output logic                      o_swap_r,
    output t_score                    o_score,
    output logic [PLAYER_ID_BITS-1:0] o_pid,
    output logic                      o_tag,
    output logic                      o_scan_a,
    output logic                      o_scan_b
);

    localparam logic [CW-1:0] IDX  = CW'(INDEX);
    localparam logic [CW-1:0] IDX1 = CW'(INDEX + 1);
    localparam logic          PAR  = 1'(INDEX % 2);

    t_score                    r_score, n_score;
    logic [PLAYER_ID_BITS-1:0] r_pid, n_pid;
    logic                      r_tag, n_tag;
    logic                      r_scan_a, n_scan_a;
    logic                      r_scan_b, n_scan_b;

    // Odd-even transposition: swap with the right neighbor only when it is strictly better
    assign o_swap_r = (i_ctrl.op == C_SORT) && (PAR == i_ctrl.phase) && (IDX1 < i_n_work)
                      && is_better(i_ctrl.desc, i_r_score, r_score);

    always_comb begin
        n_score  = r_score;
        n_pid    = r_pid;
        n_tag    = r_tag;
        n_scan_a = r_scan_a;
        n_scan_b = r_scan_b;
        unique case (i_ctrl.op)
            C_LOAD_FIND: begin
                n_scan_a = (IDX < i_sel) && (r_pid == i_pid);
                n_scan_b = is_better(i_ctrl.desc, i_ctrl.score, r_score);
            end
            C_SHIFT: begin
                n_scan_a = i_r_scan_a;
                n_scan_b = i_r_scan_b;
            end
            C_WRITE_NEW: begin
                n_tag = (IDX == i_sel);
                if (IDX == i_sel) begin
                    n_score = i_ctrl.score;
                    n_pid   = i_pid;
                end
            end
            C_REPLACE: begin
                n_tag = (IDX == i_sel);
                if (IDX == i_sel) begin
                    n_score = i_ctrl.score;
                end
            end
            C_SORT: begin
                if (o_swap_r) begin
                    n_score = i_r_score;
                    n_pid   = i_r_pid;
                    n_tag   = i_r_tag;
                end else if (i_swap_l) begin
                    n_score = i_l_score;
                    n_pid   = i_l_pid;
                    n_tag   = i_l_tag;
                end
            end
            C_LOAD_RANK: begin
                n_scan_a = (IDX < i_sel) && (r_pid == i_pid);
                n_scan_b = (IDX < i_sel) && r_tag;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_score  <= n_score;
        r_pid    <= n_pid;
        r_tag    <= n_tag;
        r_scan_a <= n_scan_a;
        r_scan_b <= n_scan_b;
    end

    assign o_score  = r_score;
    assign o_pid    = r_pid;
    assign o_tag    = r_tag;
    assign o_scan_a = r_scan_a;
    assign o_scan_b = r_scan_b;

endmodule

// ----- hw/rtl/ranked_top_k_score_table.sv -----
// Top level of the ranked top-k score table: control sequencer over a chain of cells.
// Depends on rtk_pkg, rtk_in_if, rtk_out_if, rtk_cell and the assertion macro header.
//
//  channel   dir  handshake       payload
//  i_item    in   valid/ready     action, player_id, score
//  o_res     out  valid/ready     accepted, new_top, rank, entry_count
//  i_cfg_*   in   write enable    i_cfg_idx, i_cfg_data
//
// Clear goes from transfer straight to the report step. A non-improving update and the
// unused action run only the find scan; submit, improving updates and updates of an absent
// player add the CAPACITY+1 odd-even sort phases and the rank scan through the cell chain.
// Reset (synchronous, active low) empties the table; entry storage is not cleared.
// A result waits in the output register while the next item is already taken; the report
// step stalls only while the previous result is still waiting there.
`include "ranked_top_k_score_table_macros.svh"

module ranked_top_k_score_table import rtk_pkg::*; #(
    parameter int CAPACITY       = CAPACITY_DEF,
    parameter int PLAYER_ID_BITS = PID_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rtk_in_if.sink                i_item,
    rtk_out_if.source             o_res,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(CAPACITY + 2);
    localparam int NC = CAPACITY + 1;

    // Cell chain wiring
    t_score                    w_score [NC];
    logic [PLAYER_ID_BITS-1:0] w_pid   [NC];
    logic                      w_tag   [NC];
    logic                      w_scan_a[NC];
    logic                      w_scan_b[NC];
    logic                      w_swap  [NC];

    t_state r_state, n_state;
    logic                      r_desc;
    logic [CFG_DATA_W-1:0]     r_max;
    logic [CW-1:0]             r_held, n_held;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic [CW-1:0]             r_f, n_f;
    logic [CW-1:0]             r_n_work, n_n_work;
    logic                      r_found, n_found;
    logic                      r_better, n_better;
    logic                      r_kept, n_kept;
    logic                      r_top_cand, n_top_cand;
    t_action                   r_action, n_action;
    logic [PLAYER_ID_BITS-1:0] r_pid, n_pid;
    t_score                    r_score, n_score;
    logic                      r_res_acc, n_res_acc;
    logic                      r_res_top, n_res_top;
    logic [CW-1:0]             r_res_rank, n_res_rank;
    logic                      r_out_valid, n_out_valid;
    logic                      r_out_acc, n_out_acc;
    logic                      r_out_top, n_out_top;
    logic [COUNT_W-1:0]        r_out_rank, n_out_rank;
    logic [COUNT_W-1:0]        r_out_count, n_out_count;

    t_cell_ctrl                w_ctrl;
    logic [PLAYER_ID_BITS-1:0] w_cell_pid;
    logic [CW-1:0]             w_sel;
    logic [CW-1:0]             w_lim;
    logic [CW-1:0]             w_final;
    logic                      w_accept;
    logic                      w_out_free;
    logic                      w_go_sort;
    logic                      w_found_now;
    logic [CW-1:0]             w_f_now;

    assign w_accept   = i_item.valid && i_item.ready;
    assign w_out_free = !r_out_valid || o_res.ready;

    // Entry limit and the count after pruning
    assign w_lim   = (r_max == '0 || int'(r_max) > CAPACITY) ? CW'(CAPACITY) : CW'(r_max);
    assign w_final = (r_n_work > w_lim) ? w_lim : r_n_work;

    // First match seen at the head of the chain during a scan
    assign w_found_now = r_found || w_scan_a[0];
    assign w_f_now     = r_found ? r_f : r_cnt;

    assign w_go_sort = (r_action == ACT_UPDATE && r_found) ? r_better : (r_action != ACT_NONE);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc <= 1'b1;
            r_max  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORDER: r_desc <= i_cfg_data[0];
                CFG_MAX:   r_max  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_accept) n_state = (i_item.action == ACT_CLEAR) ? S_REPORT : S_FIND;
            S_FIND:   if (r_cnt == CW'(CAPACITY - 1)) n_state = S_DECIDE;
            S_DECIDE: n_state = w_go_sort ? S_SORT : S_REPORT;
            S_SORT:   if (r_cnt == CW'(CAPACITY)) n_state = S_LOAD;
            S_LOAD:   n_state = S_RANK;
            S_RANK:   if (r_cnt == CW'(CAPACITY - 1)) n_state = S_REPORT;
            S_REPORT: if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Cell commands
    always_comb begin
        w_ctrl.op    = C_HOLD;
        w_ctrl.phase = r_cnt[0];
        w_ctrl.desc  = r_desc;
        w_ctrl.score = (r_state == S_IDLE) ? i_item.score : r_score;
        w_cell_pid   = (r_state == S_IDLE) ? PLAYER_ID_BITS'(i_item.player_id) : r_pid;
        w_sel        = r_held;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_item.action != ACT_CLEAR) w_ctrl.op = C_LOAD_FIND;
            end
            S_FIND, S_RANK: w_ctrl.op = C_SHIFT;
            S_DECIDE: begin
                if (w_go_sort) begin
                    if (r_action == ACT_UPDATE && r_found) begin
                        w_ctrl.op = C_REPLACE;
                        w_sel     = r_f;
                    end else begin
                        w_ctrl.op = C_WRITE_NEW;
                    end
                end
            end
            S_SORT: w_ctrl.op = C_SORT;
            S_LOAD: begin
                w_ctrl.op = C_LOAD_RANK;
                w_sel     = w_final;
            end
            default: begin
            end
        endcase
    end

    // Sequencer datapath
    always_comb begin
        n_held      = r_held;
        n_cnt       = r_cnt + CW'(1);
        n_f         = r_f;
        n_n_work    = r_n_work;
        n_found     = r_found;
        n_better    = r_better;
        n_kept      = r_kept;
        n_top_cand  = r_top_cand;
        n_action    = r_action;
        n_pid       = r_pid;
        n_score     = r_score;
        n_res_acc   = r_res_acc;
        n_res_top   = r_res_top;
        n_res_rank  = r_res_rank;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_acc   = r_out_acc;
        n_out_top   = r_out_top;
        n_out_rank  = r_out_rank;
        n_out_count = r_out_count;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (w_accept) begin
                    n_action   = i_item.action;
                    n_pid      = PLAYER_ID_BITS'(i_item.player_id);
                    n_score    = i_item.score;
                    n_found    = 1'b0;
                    n_top_cand = (r_held != '0) && is_better(r_desc, i_item.score, w_score[0]);
                    if (i_item.action == ACT_CLEAR) begin
                        n_held     = '0;
                        n_res_acc  = 1'b1;
                        n_res_top  = 1'b0;
                        n_res_rank = '0;
                    end
                end
            end
            S_FIND: begin
                if (!r_found && w_scan_a[0]) begin
                    n_found  = 1'b1;
                    n_f      = r_cnt;
                    n_better = w_scan_b[0];
                end
            end
            S_DECIDE: begin
                n_cnt      = '0;
                n_res_acc  = 1'b0;
                n_res_top  = 1'b0;
                n_res_rank = r_found ? r_f + CW'(1) : '0;
                if (w_go_sort) begin
                    if (r_action == ACT_UPDATE && r_found) begin
                        n_n_work = r_held;
                    end else begin
                        n_n_work  = r_held + CW'(1);
                        n_res_top = r_top_cand;
                    end
                end
            end
            S_LOAD: begin
                n_held  = w_final;
                n_cnt   = '0;
                n_found = 1'b0;
                n_kept  = 1'b0;
            end
            S_RANK: begin
                if (!r_found && w_scan_a[0]) begin
                    n_found = 1'b1;
                    n_f     = r_cnt;
                end
                n_kept     = r_kept || w_scan_b[0];
                n_res_acc  = r_kept || w_scan_b[0];
                n_res_rank = w_found_now ? w_f_now + CW'(1) : '0;
            end
            S_REPORT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_acc   = r_res_acc;
                    n_out_top   = r_res_top;
                    n_out_rank  = COUNT_W'(r_res_rank);
                    n_out_count = COUNT_W'(r_held);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_cnt       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_cnt       <= n_cnt;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f         <= n_f;
        r_n_work    <= n_n_work;
        r_better    <= n_better;
        r_kept      <= n_kept;
        r_top_cand  <= n_top_cand;
        r_action    <= n_action;
        r_pid       <= n_pid;
        r_score     <= n_score;
        r_res_acc   <= n_res_acc;
        r_res_top   <= n_res_top;
        r_res_rank  <= n_res_rank;
        r_out_acc   <= n_out_acc;
        r_out_top   <= n_out_top;
        r_out_rank  <= n_out_rank;
        r_out_count <= n_out_count;
    end

    // Cell chain
    for (genvar i = 0; i < NC; i++) begin : g_cell
        t_score                    w_r_score;
        logic [PLAYER_ID_BITS-1:0] w_r_pid;
        logic                      w_r_tag;
        logic                      w_r_scan_a;
        logic                      w_r_scan_b;
        t_score                    w_l_score;
        logic [PLAYER_ID_BITS-1:0] w_l_pid;
        logic                      w_l_tag;
        logic                      w_swap_l;

        if (i == NC - 1) begin : g_last
            assign w_r_score  = '0;
            assign w_r_pid    = '0;
            assign w_r_tag    = 1'b0;
            assign w_r_scan_a = 1'b0;
            assign w_r_scan_b = 1'b0;
        end else begin : g_mid
            assign w_r_score  = w_score[i+1];
            assign w_r_pid    = w_pid[i+1];
            assign w_r_tag    = w_tag[i+1];
            assign w_r_scan_a = w_scan_a[i+1];
            assign w_r_scan_b = w_scan_b[i+1];
        end

        if (i == 0) begin : g_first
            assign w_l_score = '0;
            assign w_l_pid   = '0;
            assign w_l_tag   = 1'b0;
            assign w_swap_l  = 1'b0;
        end else begin : g_follow
            assign w_l_score = w_score[i-1];
            assign w_l_pid   = w_pid[i-1];
            assign w_l_tag   = w_tag[i-1];
            assign w_swap_l  = w_swap[i-1];
        end

        rtk_cell #(
            .CAPACITY       (CAPACITY),
            .PLAYER_ID_BITS (PLAYER_ID_BITS),
            .INDEX          (i)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_pid      (w_cell_pid),
            .i_sel      (w_sel),
            .i_n_work   (r_n_work),
            .i_r_score  (w_r_score),
            .i_r_pid    (w_r_pid),
            .i_r_tag    (w_r_tag),
            .i_r_scan_a (w_r_scan_a),
            .i_r_scan_b (w_r_scan_b),
            .i_l_score  (w_l_score),
            .i_l_pid    (w_l_pid),
            .i_l_tag    (w_l_tag),
            .i_swap_l   (w_swap_l),
            .o_swap_r   (w_swap[i]),
            .o_score    (w_score[i]),
            .o_pid      (w_pid[i]),
            .o_tag      (w_tag[i]),
            .o_scan_a   (w_scan_a[i]),
            .o_scan_b   (w_scan_b[i])
        );
    end

    // Ports
    assign i_item.ready      = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.accepted    = r_out_acc;
    assign o_res.new_top     = r_out_top;
    assign o_res.rank        = r_out_rank;
    assign o_res.entry_count = r_out_count;

    // Assertions
    `RTK_ASSERT_IMP(a_held_cap, i_clk, i_rst_n, 1'b1, r_held <= CW'(CAPACITY), "held count beyond capacity")
    `RTK_ASSERT_NXT(a_clear_empties, i_clk, i_rst_n, w_accept && i_item.action == ACT_CLEAR, r_held == '0 && r_state == S_REPORT, "clear did not empty table")
    `RTK_ASSERT_NXT(a_found_sticky, i_clk, i_rst_n, r_state == S_FIND && r_found, r_found, "find result lost during scan")
    `RTK_ASSERT_IMP(a_sort_bound, i_clk, i_rst_n, r_state == S_SORT, r_n_work <= CW'(CAPACITY + 1), "sort length beyond chain")

endmodule
